[hdl/mnfw_pkg.sv]
// Shared types, constants and the divider step function for the filter weight block.
`default_nettype none

package mnfw_pkg;

	// fixed-point formats
	localparam int WFB = 14;               // weight / t fraction bits
	localparam int ONE = 1 << WFB;         // 1.0 in the weight format
	localparam int DIV_BITS = 3;           // quotient bits resolved per divider stage

	// register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_B      = 2'd1,
		REG_C      = 2'd2
	} reg_idx_t;

	// polynomial coefficient, wide enough for 60 * (-32768)
	typedef logic signed [22:0] coef_t;

	// product of a coefficient and a power of t
	typedef logic signed [40:0] prod_t;

	// partial remainder and quotient of t = mag * 2^15 / radius
	typedef struct packed {
		logic [14:0] rem;
		logic [14:0] quo;
	} div_t;

	// reset values
	localparam logic [14:0]        RADIUS_RST = 15'd8192;
	localparam logic signed [15:0] B_RST      = 16'sd5461;
	localparam logic signed [15:0] C_RST      = 16'sd5461;

	// rounding offset before the return to Q.14: 3 * 2^14
	localparam logic signed [42:0] ROUND_ADJ = 43'sd49152;

	// the scaled sum is 3 * weight; limits of the 16-bit weight times three
	localparam logic signed [27:0] S_HI = 28'sd98304;
	localparam logic signed [27:0] S_LO = -28'sd98304;

	// floor(u / 3) = (u * RECIP3) >> RECIP3_SH, exact for u < 2^18
	localparam logic [35:0] RECIP3    = 36'd174763;
	localparam int          RECIP3_SH = 19;

	// weight code with the sign bit flipped back after the bias of 32768
	localparam logic [15:0] W_BIAS = 16'h8000;
	localparam logic [15:0] W_MAX  = 16'h7fff;
	localparam logic [15:0] W_MIN  = 16'h8000;

	// restoring division, DIV_BITS quotient bits; rem < rad on entry
	function automatic div_t div_step(div_t d, logic [14:0] rad);
		div_t r;
		logic [15:0] sh;
		r = d;
		for (int i = 0; i < DIV_BITS; i++) begin
			sh = {r.rem, 1'b0};
			if (sh >= {1'b0, rad}) begin
				r.rem = 15'(sh - {1'b0, rad});
				r.quo = {r.quo[13:0], 1'b1};
			end else begin
				r.rem = sh[14:0];
				r.quo = {r.quo[13:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/mitchell_netravali_filter_weight.sv]
// Mitchell-Netravali cubic filter weight: register file and 12-stage evaluation pipeline.
//
// Usage:
//   Input channel in_valid / in_stall / offset carries one signed Q4.12 offset per item.
//   Output channel out_valid / out_stall / weight, outside_support, saturated returns
//   one result item per input item, in order. weight is signed Q2.14.
//   radius (Q3.12), b_param and c_param (Q2.14) sit at byte addresses 0, 4 and 8 of
//   the APB port; write them only while no item is in flight.
// Timing:
//   Each accepted item passes through the 12 registered stages below, and out_valid
//   then rises for it. One item per cycle is taken sustained while out_stall is low.
//   A magnitude and support stage feeds the division t = 2|x|/radius, a
//   five-stage restoring divider with three quotient bits per stage, followed by two
//   squaring/cubing multiplier stages, a coefficient multiply stage, a sum stage, a
//   clamp stage and a divide-by-three multiply stage that also holds the output.
// Reset:
//   arst_n clears all valid bits and loads radius 2.0 and B = C = 1/3.
// Stall:
//   Each stage moves forward when it is empty or the next stage moves, so while
//   out_stall is high the output item holds and bubbles further up still fill;
//   in_stall rises only once all 12 stages hold items.
`default_nettype none

module mitchell_netravali_filter_weight (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] offset,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      weight,
	output logic                    outside_support,
	output logic                    saturated,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int NSTG = 12;

	// configuration registers
	logic [14:0]        radius_q;
	logic signed [15:0] b_q;
	logic signed [15:0] c_q;
	logic               cfg_wr;
	mnfw_pkg::reg_idx_t cfg_idx;

	// coefficients, refreshed every cycle from B and C
	mnfw_pkg::coef_t in_a3_q, in_a2_q, in_a0_q;
	mnfw_pkg::coef_t out_a3_q, out_a2_q, out_a1_q, out_a0_q;
	mnfw_pkg::coef_t bx, cx;

	// pipeline control
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;

	// stage payloads
	logic [16:0]        mag;
	logic signed [16:0] off_x;
	logic [14:0]        rem_s1;
	logic               outs_s1;
	mnfw_pkg::div_t     dv_s2, dv_s3, dv_s4, dv_s5, dv_s6;
	logic               outs_s2, outs_s3, outs_s4, outs_s5, outs_s6;
	logic [29:0]        sq;
	logic [15:0]        t2_s7;
	logic [14:0]        t_s7;
	logic               outs_s7;
	logic [30:0]        cb;
	logic [16:0]        t3_s8;
	logic [15:0]        t2_s8;
	logic [14:0]        t_s8;
	logic               outs_s8;
	mnfw_pkg::coef_t    a3_sel, a2_sel, a1_sel, a0_sel;
	logic signed [17:0] t3x;
	logic signed [16:0] t2x;
	logic signed [15:0] tx;
	mnfw_pkg::prod_t    p3_c, p2_c, p1_c;
	mnfw_pkg::prod_t    p3_s9, p2_s9, p1_s9;
	logic signed [36:0] a0t_s9;
	logic               outs_s9;
	logic signed [42:0] sum_c;
	logic signed [27:0] s_s10;
	logic               outs_s10;
	logic [17:0]        u_s11;
	logic               sat_hi_s11, sat_lo_s11, outs_s11;
	logic [35:0]        qp;
	logic [15:0]        q16;
	logic signed [15:0] w_s12;
	logic               outs_s12, sat_s12;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = mnfw_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= mnfw_pkg::RADIUS_RST;
			b_q      <= mnfw_pkg::B_RST;
			c_q      <= mnfw_pkg::C_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mnfw_pkg::REG_RADIUS: radius_q <= pwdata[14:0];
				mnfw_pkg::REG_B:      b_q      <= $signed(pwdata[15:0]);
				mnfw_pkg::REG_C:      c_q      <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (cfg_idx)
			mnfw_pkg::REG_RADIUS: prdata = {17'b0, radius_q};
			mnfw_pkg::REG_B:      prdata = 32'(b_q);
			mnfw_pkg::REG_C:      prdata = 32'(c_q);
			default:              prdata = 32'b0;
		endcase
	end

	// kernel coefficients in Q.14, inner and outer piece
	assign bx = mnfw_pkg::coef_t'(b_q);
	assign cx = mnfw_pkg::coef_t'(c_q);

	always_ff @(posedge clk) begin
		in_a3_q  <= mnfw_pkg::coef_t'(12 * mnfw_pkg::ONE) - mnfw_pkg::coef_t'(9) * bx
			- mnfw_pkg::coef_t'(6) * cx;
		in_a2_q  <= mnfw_pkg::coef_t'(12) * bx + mnfw_pkg::coef_t'(6) * cx
			- mnfw_pkg::coef_t'(18 * mnfw_pkg::ONE);
		in_a0_q  <= mnfw_pkg::coef_t'(6 * mnfw_pkg::ONE) - mnfw_pkg::coef_t'(2) * bx;
		out_a3_q <= -bx - mnfw_pkg::coef_t'(6) * cx;
		out_a2_q <= mnfw_pkg::coef_t'(6) * bx + mnfw_pkg::coef_t'(30) * cx;
		out_a1_q <= -(mnfw_pkg::coef_t'(12) * bx) - mnfw_pkg::coef_t'(48) * cx;
		out_a0_q <= mnfw_pkg::coef_t'(8) * bx + mnfw_pkg::coef_t'(24) * cx;
	end

	// ---------------- pipeline flow control ----------------
	// a stage loads when it is empty or its content moves on
	always_comb begin
		adv[NSTG+1] = ~out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign in_stall = ~adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ---------------- s1: magnitude and support test ----------------
	assign off_x = 17'(offset);
	assign mag   = offset[15] ? 17'(-off_x) : 17'(off_x);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			rem_s1  <= mag[14:0];
			outs_s1 <= (radius_q == 15'd0) || (mag >= {2'b0, radius_q});
		end
	end

	// ---------------- s2..s6: t = mag * 2^15 / radius ----------------
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dv_s2   <= mnfw_pkg::div_step(mnfw_pkg::div_t'{rem: rem_s1, quo: 15'd0},
				radius_q);
			outs_s2 <= outs_s1;
		end
		if (adv[3]) begin
			dv_s3   <= mnfw_pkg::div_step(dv_s2, radius_q);
			outs_s3 <= outs_s2;
		end
		if (adv[4]) begin
			dv_s4   <= mnfw_pkg::div_step(dv_s3, radius_q);
			outs_s4 <= outs_s3;
		end
		if (adv[5]) begin
			dv_s5   <= mnfw_pkg::div_step(dv_s4, radius_q);
			outs_s5 <= outs_s4;
		end
		if (adv[6]) begin
			dv_s6   <= mnfw_pkg::div_step(dv_s5, radius_q);
			outs_s6 <= outs_s5;
		end
	end

	// ---------------- s7: t^2, s8: t^3 ----------------
	assign sq = 30'(dv_s6.quo) * 30'(dv_s6.quo);
	assign cb = 31'(t2_s7) * 31'(t_s7);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			t2_s7   <= sq[mnfw_pkg::WFB +: 16];
			t_s7    <= dv_s6.quo;
			outs_s7 <= outs_s6;
		end
		if (adv[8]) begin
			t3_s8   <= cb[mnfw_pkg::WFB +: 17];
			t2_s8   <= t2_s7;
			t_s8    <= t_s7;
			outs_s8 <= outs_s7;
		end
	end

	// ---------------- s9: coefficient products ----------------
	// t < 1 selects the inner cubic (no linear term)
	always_comb begin
		if (!t_s8[mnfw_pkg::WFB]) begin
			a3_sel = in_a3_q;
			a2_sel = in_a2_q;
			a1_sel = '0;
			a0_sel = in_a0_q;
		end else begin
			a3_sel = out_a3_q;
			a2_sel = out_a2_q;
			a1_sel = out_a1_q;
			a0_sel = out_a0_q;
		end
	end

	assign t3x  = $signed({1'b0, t3_s8});
	assign t2x  = $signed({1'b0, t2_s8});
	assign tx   = $signed({1'b0, t_s8});
	assign p3_c = mnfw_pkg::prod_t'(a3_sel) * mnfw_pkg::prod_t'(t3x);
	assign p2_c = mnfw_pkg::prod_t'(a2_sel) * mnfw_pkg::prod_t'(t2x);
	assign p1_c = mnfw_pkg::prod_t'(a1_sel) * mnfw_pkg::prod_t'(tx);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			p3_s9   <= p3_c;
			p2_s9   <= p2_c;
			p1_s9   <= p1_c;
			a0t_s9  <= {a0_sel, {mnfw_pkg::WFB{1'b0}}};
			outs_s9 <= outs_s8;
		end
	end

	// s10: sum, rounding, back to Q.14 times three
	// floor((sum + 3*2^14) / 2^15) leaves 3 * weight before the final floor
	assign sum_c = 43'(p3_s9) + 43'(p2_s9) + 43'(p1_s9) + 43'(a0t_s9) + mnfw_pkg::ROUND_ADJ;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			s_s10    <= sum_c[42:15];
			outs_s10 <= outs_s9;
		end
	end

	// ---------------- s11: clamp test and bias ----------------
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			sat_hi_s11 <= s_s10 >= mnfw_pkg::S_HI;
			sat_lo_s11 <= s_s10 < mnfw_pkg::S_LO;
			u_s11      <= 18'(s_s10 - mnfw_pkg::S_LO);
			outs_s11   <= outs_s10;
		end
	end

	// ---------------- s12: floor divide by three, output register ----------------
	assign qp  = 36'(u_s11) * mnfw_pkg::RECIP3;
	assign q16 = qp[mnfw_pkg::RECIP3_SH +: 16];

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			outs_s12 <= outs_s11;
			if (outs_s11) begin
				w_s12   <= '0;
				sat_s12 <= 1'b0;
			end else if (sat_hi_s11) begin
				w_s12   <= $signed(mnfw_pkg::W_MAX);
				sat_s12 <= 1'b1;
			end else if (sat_lo_s11) begin
				w_s12   <= $signed(mnfw_pkg::W_MIN);
				sat_s12 <= 1'b1;
			end else begin
				w_s12   <= $signed(q16 - mnfw_pkg::W_BIAS);
				sat_s12 <= 1'b0;
			end
		end
	end

	assign out_valid       = vld_q[NSTG];
	assign weight          = w_s12;
	assign outside_support = outs_s12;
	assign saturated       = sat_s12;

endmodule

`default_nettype wire

[hdl/mnfw_chk.sv]
// Port-level checker for the filter weight block, bound to the top level.
`default_nettype none

module mnfw_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic signed [15:0] offset,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] weight,
	input wire logic               outside_support,
	input wire logic               saturated
);

	// a stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(offset))
		else $error("input item changed while stalled");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight)
			&& $stable(outside_support) && $stable(saturated))
		else $error("output item changed while stalled");

	// a free output never backs up the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// outside the support the weight is zero and not clipped
	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside_support |-> weight == 16'sd0 && !saturated)
		else $error("nonzero weight outside support");

	// a clipped weight sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> weight == 16'sh7fff || weight == -16'sh8000)
		else $error("saturated weight not at a rail");

endmodule

bind mitchell_netravali_filter_weight mnfw_chk u_mnfw_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.offset          (offset),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.weight          (weight),
	.outside_support (outside_support),
	.saturated       (saturated)
);

`default_nettype wire
